[sv/aes_cbc_pkg.sv]
// AES-128 CBC package: beat types, S-box and GF helpers, register indexes.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
package aes_cbc_pkg;

   localparam int unsigned NumRounds = 10;
   localparam int unsigned CsrIdxW   = 2;

   localparam logic [CsrIdxW-1:0] CSR_KEY_HIGH = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_KEY_LOW  = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_IV_HIGH  = 2'd2;
   localparam logic [CsrIdxW-1:0] CSR_IV_LOW   = 2'd3;

   typedef struct packed {
      logic [63:0] plain_high;
      logic [63:0] plain_low;
      logic        first_block;
   } req_type;

   typedef struct packed {
      logic [63:0] cipher_high;
      logic [63:0] cipher_low;
   } rsp_type;

   // round control from the sequencer to the round unit
   typedef struct packed {
      logic       load;
      logic       step;
      logic       last;
      logic [7:0] rcon;
   } round_ctl_type;

   function automatic logic [7:0] sbox(input logic [7:0] a);
      logic [7:0] t [256];
      t = '{
       8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
       8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
       8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
       8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
       8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
       8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
       8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
       8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
       8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
       8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
       8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
       8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
       8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
       8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
       8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
       8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16};
      return t[a];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1B : 8'h00);
   endfunction

   // next round constant
   function automatic logic [7:0] rcon_next(input logic [7:0] r);
      return xtime(r);
   endfunction

endpackage

[sv/aes_cbc_round.sv]
// AES-128 round unit: one cipher round and one key-schedule round per step.
// Depends on aes_cbc_pkg for the S-box, xtime and control struct.
`timescale 1ns / 1ps
module aes_cbc_round (
   input  logic                       clock,
   input  aes_cbc_pkg::round_ctl_type ctl,
   input  logic [127:0]               load_state,
   input  logic [127:0]               load_key,
   output logic [127:0]               state
);

   logic [127:0] state_ff, state_in;
   logic [127:0] rkey_ff, rkey_in;
   logic [7:0]   s [16];
   logic [7:0]   m [16];
   logic [31:0]  w [4];
   logic [31:0]  t;

   // next round key from the current one
   always_comb begin
      t = {aes_cbc_pkg::sbox(rkey_ff[23:16]), aes_cbc_pkg::sbox(rkey_ff[15:8]),
           aes_cbc_pkg::sbox(rkey_ff[7:0]),   aes_cbc_pkg::sbox(rkey_ff[31:24])};
      t = t ^ {ctl.rcon, 24'h0};
      w[0] = rkey_ff[127:96] ^ t;
      w[1] = rkey_ff[95:64]  ^ w[0];
      w[2] = rkey_ff[63:32]  ^ w[1];
      w[3] = rkey_ff[31:0]   ^ w[2];
   end

   // SubBytes, ShiftRows, MixColumns (skipped in the last round), AddRoundKey; byte i at bits 127-8i
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            s[4*c+r] = aes_cbc_pkg::sbox(state_ff[127-8*(4*((c+r)%4)+r) -: 8]);
         end
      end
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            m[4*c+r] = s[4*c+r] ^ s[4*c] ^ s[4*c+1] ^ s[4*c+2] ^ s[4*c+3]
                       ^ aes_cbc_pkg::xtime(s[4*c+r] ^ s[4*c+((r+1)%4)]);
         end
      end
      for (int i = 0; i < 16; i++) begin
         state_in[127-8*i -: 8] = (ctl.last ? s[i] : m[i]) ^ rkey_in[127-8*i -: 8];
      end
   end

   assign rkey_in = {w[0], w[1], w[2], w[3]};

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         state_ff <= load_state ^ load_key;
         rkey_ff  <= load_key;
      end else if (ctl.step) begin
         state_ff <= state_in;
         rkey_ff  <= rkey_in;
      end
   end

   assign state = state_ff;

endmodule

[sv/aes128_cbc_encrypt_top.sv]
// AES-128 CBC encryption top level: registers, sequencer, round unit, chaining register.
// Depends on aes_cbc_pkg and aes_cbc_round.
`timescale 1ns / 1ps
// One block at a time: a beat is taken, the plaintext is XORed with the
// chaining value and the key, then one shared round unit runs the ten rounds,
// one a cycle, with the key schedule expanded alongside; the ciphertext stays
// in the round unit's state register, and the next block is taken once the
// result has left. The rate is set by the single round unit. Key and IV are
// to be written by the user between blocks only; the block does not enforce this.
module aes128_cbc_encrypt_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  aes_cbc_pkg::req_type         req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output aes_cbc_pkg::rsp_type         rsp_data,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [aes_cbc_pkg::CsrIdxW-1:0] csr_index,
   input  logic [63:0]                  csr_wdata
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_OUT  = 2'd2;

   logic [1:0]   st_ff, st_in;
   logic [3:0]   rnd_ff, rnd_in;
   logic [7:0]   rcon_ff, rcon_in;
   logic [63:0]  key_hi_ff, key_lo_ff, iv_hi_ff, iv_lo_ff;
   logic [127:0] chain_ff;
   logic [127:0] cipher;
   logic [127:0] start_state;
   logic         req_take, rsp_take;
   aes_cbc_pkg::round_ctl_type ctl;

   assign req_stall = (st_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = (st_ff == ST_OUT);
   assign rsp_take  = rsp_valid && !rsp_stall;
   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_hi_ff <= '0;
         key_lo_ff <= '0;
         iv_hi_ff  <= '0;
         iv_lo_ff  <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            aes_cbc_pkg::CSR_KEY_HIGH: key_hi_ff <= csr_wdata;
            aes_cbc_pkg::CSR_KEY_LOW:  key_lo_ff <= csr_wdata;
            aes_cbc_pkg::CSR_IV_HIGH:  iv_hi_ff  <= csr_wdata;
            aes_cbc_pkg::CSR_IV_LOW:   iv_lo_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign start_state = {req_data.plain_high, req_data.plain_low} ^
      (req_data.first_block ? {iv_hi_ff, iv_lo_ff} : chain_ff);

   // sequencer
   always_comb begin
      st_in   = st_ff;
      rnd_in  = rnd_ff;
      rcon_in = rcon_ff;
      unique case (st_ff)
         ST_IDLE: if (req_take) begin
            st_in   = ST_RUN;
            rnd_in  = 4'd1;
            rcon_in = 8'h01;
         end
         ST_RUN: begin
            rnd_in  = rnd_ff + 4'd1;
            rcon_in = aes_cbc_pkg::rcon_next(rcon_ff);
            if (rnd_ff == 4'(aes_cbc_pkg::NumRounds)) st_in = ST_OUT;
         end
         ST_OUT: if (rsp_take) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= ST_IDLE;
         rnd_ff  <= '0;
         rcon_ff <= 8'h01;
      end else begin
         st_ff   <= st_in;
         rnd_ff  <= rnd_in;
         rcon_ff <= rcon_in;
      end
   end

   assign ctl.load = req_take;
   assign ctl.step = (st_ff == ST_RUN);
   assign ctl.last = (rnd_ff == 4'(aes_cbc_pkg::NumRounds));
   assign ctl.rcon = rcon_ff;

   aes_cbc_round u_round (
      .clock      (clock),
      .ctl        (ctl),
      .load_state (start_state),
      .load_key   ({key_hi_ff, key_lo_ff}),
      .state      (cipher)
   );

   // chaining value takes the ciphertext as its beat leaves
   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= '0;
      end else if (rsp_take) begin
         chain_ff <= cipher;
      end
   end

   assign rsp_data.cipher_high = cipher[127:64];
   assign rsp_data.cipher_low  = cipher[63:0];

   // chain register holds the result that has just left
   a_chain: assert property (@(posedge clock) disable iff (reset)
      rsp_take |=> chain_ff == $past(cipher))
      else $error("chain value differs from result");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_take |=> !rsp_valid && req_stall)
      else $error("result shown too early");
   a_rnd: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_RUN) |-> (rnd_ff != 4'd0 && rnd_ff <= 4'(aes_cbc_pkg::NumRounds)))
      else $error("round count out of range");

endmodule

[tb/aes128_cbc_encrypt_top_test.sv]
// Testbench for aes128_cbc_encrypt_top: CBC chaining and key/IV registers
// against an in-bench AES-128 cipher. Depends on aes_cbc_pkg and the block.
`timescale 1ns / 1ps
module aes128_cbc_encrypt_top_test;

   localparam int unsigned NumRandom  = 1800;
   localparam int unsigned WatchLimit = 20000;
   localparam int unsigned DrainWait  = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   aes_cbc_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   aes_cbc_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [aes_cbc_pkg::CsrIdxW-1:0] csr_index = '0;
   logic [63:0] csr_wdata = '0;

   aes128_cbc_encrypt_top u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // bench copy of the registers and chaining value
   logic [63:0] key_hi_m, key_lo_m, iv_hi_m, iv_lo_m, chain_hi_m, chain_lo_m;
   aes_cbc_pkg::req_type plain_q [$];
   aes_cbc_pkg::rsp_type cipher_q [$];
   int unsigned fail_count = 0;
   int unsigned idle_cycles = 0;
   int unsigned burst_left = 0, gap_left = 0;
   int unsigned rsp_mode = 0;
   logic [7:0] sbox_m [256];

   function automatic logic [7:0] gmul2(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1B : 8'h00);
   endfunction

   // full AES-128 encryption of one block with the current key
   function automatic logic [127:0] aes_encrypt(input logic [127:0] blk,
                                                input logic [127:0] key);
      logic [31:0] w [44];
      logic [7:0] s [16];
      logic [7:0] t [16];
      logic [31:0] tmp;
      logic [7:0] rc, a0, a1, a2, a3, all;
      logic [127:0] res;
      rc = 8'h01;
      for (int i = 0; i < 4; i++) w[i] = key[127-32*i -: 32];
      for (int i = 4; i < 44; i++) begin
         tmp = w[i-1];
         if (i % 4 == 0) begin
            tmp = {tmp[23:0], tmp[31:24]};
            tmp = {sbox_m[tmp[31:24]], sbox_m[tmp[23:16]], sbox_m[tmp[15:8]],
                   sbox_m[tmp[7:0]]} ^ {rc, 24'h0};
            rc = gmul2(rc);
         end
         w[i] = w[i-4] ^ tmp;
      end
      for (int i = 0; i < 16; i++) s[i] = blk[127-8*i -: 8];
      for (int rnd = 0; rnd <= 10; rnd++) begin
         if (rnd > 0) begin
            for (int c = 0; c < 4; c++)
               for (int r = 0; r < 4; r++) t[4*c+r] = sbox_m[s[4*((c+r)%4)+r]];
            s = t;
            if (rnd < 10) begin
               for (int c = 0; c < 4; c++) begin
                  a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
                  all = a0 ^ a1 ^ a2 ^ a3;
                  s[4*c]   = a0 ^ all ^ gmul2(a0 ^ a1);
                  s[4*c+1] = a1 ^ all ^ gmul2(a1 ^ a2);
                  s[4*c+2] = a2 ^ all ^ gmul2(a2 ^ a3);
                  s[4*c+3] = a3 ^ all ^ gmul2(a3 ^ a0);
               end
            end
         end
         for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) s[4*c+r] ^= w[rnd*4+c][31-8*r -: 8];
      end
      for (int i = 0; i < 16; i++) res[127-8*i -: 8] = s[i];
      return res;
   endfunction

   // predict the ciphertext of one accepted beat and advance the chain
   function automatic void predict_cipher(input aes_cbc_pkg::req_type p);
      logic [127:0] x, c;
      aes_cbc_pkg::rsp_type e;
      x = p.first_block ? {p.plain_high ^ iv_hi_m, p.plain_low ^ iv_lo_m}
                        : {p.plain_high ^ chain_hi_m, p.plain_low ^ chain_lo_m};
      c = aes_encrypt(x, {key_hi_m, key_lo_m});
      chain_hi_m = c[127:64];
      chain_lo_m = c[63:0];
      e.cipher_high = c[127:64];
      e.cipher_low = c[63:0];
      cipher_q.push_back(e);
   endfunction

   function automatic aes_cbc_pkg::req_type rand_plain(input bit first);
      aes_cbc_pkg::req_type p;
      p.plain_high = {$urandom, $urandom};
      p.plain_low = {$urandom, $urandom};
      p.first_block = first;
      return p;
   endfunction

   // driver: bursts and gaps, payload held while stalled
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predict_cipher(req_data);
            void'(plain_q.pop_front());
         end
         if (req_valid && req_stall) begin
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (plain_q.size() > 0) begin
            req_valid <= 1'b1;
            req_data <= plain_q[0];
            if (burst_left == 0) begin
               burst_left <= $urandom_range(1, 12);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 30);
            end else burst_left <= burst_left - 1;
         end else req_valid <= 1'b0;
      end
   end

   // monitor and receiver stall pattern
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (cipher_q.size() == 0) begin
               $error("unexpected beat: cipher_high %h cipher_low %h",
                      rsp_data.cipher_high, rsp_data.cipher_low);
               fail_count++;
            end else begin
               if (rsp_data.cipher_high !== cipher_q[0].cipher_high) begin
                  $error("cipher_high expected %h actual %h",
                         cipher_q[0].cipher_high, rsp_data.cipher_high);
                  fail_count++;
               end
               if (rsp_data.cipher_low !== cipher_q[0].cipher_low) begin
                  $error("cipher_low expected %h actual %h",
                         cipher_q[0].cipher_low, rsp_data.cipher_low);
                  fail_count++;
               end
               void'(cipher_q.pop_front());
            end
         end
         if ($urandom_range(0, 199) == 0) rsp_mode <= $urandom_range(0, 2);
         case (rsp_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            default: rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
         // watchdog on accepted beats
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WatchLimit) begin
            $display("aes128_cbc_encrypt_top_test: done, errors");
            $finish;
         end
      end
   end

   task automatic write_reg(input logic [aes_cbc_pkg::CsrIdxW-1:0] idx,
                            input logic [63:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         aes_cbc_pkg::CSR_KEY_HIGH: key_hi_m = val;
         aes_cbc_pkg::CSR_KEY_LOW:  key_lo_m = val;
         aes_cbc_pkg::CSR_IV_HIGH:  iv_hi_m = val;
         default:                   iv_lo_m = val;
      endcase
   endtask

   // wait for the block to drain before touching the registers
   task automatic wait_quiet();
      while (plain_q.size() != 0 || cipher_q.size() != 0) @(posedge clock);
      repeat (DrainWait) @(posedge clock);
   endtask

   function automatic logic [63:0] pick_value();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   initial begin
      aes_cbc_pkg::req_type p;
      for (int i = 0; i < 256; i++) sbox_m[i] = aes_cbc_pkg::sbox(i[7:0]);
      key_hi_m = '0; key_lo_m = '0; iv_hi_m = '0; iv_lo_m = '0;
      chain_hi_m = '0; chain_lo_m = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      // no block since reset, chaining from zero; then zero IV with zero key
      plain_q.push_back(rand_plain(1'b0));
      p = '0; plain_q.push_back(p);
      p.first_block = 1'b1; plain_q.push_back(p);
      wait_quiet();
      // standard test vector key, IV and first block, then all-ones and all-zero data
      write_reg(aes_cbc_pkg::CSR_KEY_HIGH, 64'h2b7e151628aed2a6);
      write_reg(aes_cbc_pkg::CSR_KEY_LOW, 64'habf7158809cf4f3c);
      write_reg(aes_cbc_pkg::CSR_IV_HIGH, 64'h0001020304050607);
      write_reg(aes_cbc_pkg::CSR_IV_LOW, 64'h08090a0b0c0d0e0f);
      p.plain_high = 64'h6bc1bee22e409f96; p.plain_low = 64'he93d7e117393172a;
      p.first_block = 1'b1; plain_q.push_back(p);
      p.plain_high = '1; p.plain_low = '1; p.first_block = 1'b0; plain_q.push_back(p);
      p.plain_high = '0; p.plain_low = '0; plain_q.push_back(p);
      wait_quiet();
      // all-ones key and IV; IV change only matters at the next first block
      write_reg(aes_cbc_pkg::CSR_KEY_HIGH, '1); write_reg(aes_cbc_pkg::CSR_KEY_LOW, '1);
      write_reg(aes_cbc_pkg::CSR_IV_HIGH, '1); write_reg(aes_cbc_pkg::CSR_IV_LOW, '1);
      plain_q.push_back(rand_plain(1'b0));
      plain_q.push_back(rand_plain(1'b1));
      plain_q.push_back(rand_plain(1'b0));
      wait_quiet();
      // random phases: CBC messages of random length, keys and IVs changed between
      for (int ph = 0; ph < 12; ph++) begin
         write_reg(aes_cbc_pkg::CSR_KEY_HIGH, pick_value());
         write_reg(aes_cbc_pkg::CSR_KEY_LOW, pick_value());
         write_reg(aes_cbc_pkg::CSR_IV_HIGH, pick_value());
         write_reg(aes_cbc_pkg::CSR_IV_LOW, pick_value());
         for (int n = 0; n < NumRandom / 12; ) begin
            int unsigned len;
            len = $urandom_range(1, 10);
            for (int k = 0; k < len; k++) plain_q.push_back(rand_plain(k == 0));
            if ($urandom_range(0, 4) == 0)
               plain_q.push_back(rand_plain(1'($urandom_range(0, 1))));
            n += len;
         end
         wait_quiet();
      end
      if (fail_count == 0)
         $display("aes128_cbc_encrypt_top_test: done, clean");
      else
         $display("aes128_cbc_encrypt_top_test: done, errors");
      $finish;
   end

endmodule
